/* rtl/core/skf_pkg.sv */
package skf_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int GAIN_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int GAIN_W     = GAIN_BITS + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_STEPS  = GAIN_W;
    localparam int CNT_W      = 5;
    localparam int OUT_TDATA_W = ((2 * DATA_W + GAIN_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 2'd1;

    localparam logic [DATA_W-1:0] PN_RESET  = 32'd65;
    localparam logic [DATA_W-1:0] MN_RESET  = 32'd65536;
    localparam logic [DATA_W-1:0] VAR_RESET = DATA_W'(64'd1 << FRAC_BITS);
    localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(32'd1 << GAIN_BITS);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PRED  = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_MUL_E = 6'b001000,
        ST_MUL_V = 6'b010000,
        ST_FIN   = 6'b100000
    } t_state;

    typedef struct packed {
        logic load;
        logic pred;
        logic div_step;
        logic mul_est;
        logic mul_var;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

/* rtl/core/skf_ctrl.sv */
module skf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  skf_pkg::t_status i_status,
    output skf_pkg::t_cmd    o_cmd
);

    skf_pkg::t_state r_state, n_state;
    logic [skf_pkg::CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skf_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            skf_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = skf_pkg::ST_PRED;
                end
            end
            skf_pkg::ST_PRED: begin
                o_cmd.pred = 1'b1;
                n_cnt      = '0;
                n_state    = skf_pkg::ST_DIV;
            end
            skf_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == skf_pkg::CNT_W'(skf_pkg::DIV_STEPS - 1)) begin
                    n_state = skf_pkg::ST_MUL_E;
                end
            end
            skf_pkg::ST_MUL_E: begin
                o_cmd.mul_est = 1'b1;
                n_state       = skf_pkg::ST_MUL_V;
            end
            skf_pkg::ST_MUL_V: begin
                o_cmd.mul_var = 1'b1;
                n_state       = skf_pkg::ST_FIN;
            end
            skf_pkg::ST_FIN: begin
                // hold the result until the output register can take it
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = skf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = skf_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == skf_pkg::ST_IDLE);

endmodule

/* rtl/core/skf_dp.sv */
module skf_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [skf_pkg::CFG_IDX_W-1:0]       i_cfg_addr,
    input  logic [skf_pkg::DATA_W-1:0]          i_cfg_data,
    input  logic [skf_pkg::DATA_W-1:0]          i_meas,
    input  skf_pkg::t_cmd                       i_cmd,
    output skf_pkg::t_status                    o_status,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [skf_pkg::DATA_W-1:0]          o_estimate,
    output logic [skf_pkg::DATA_W-1:0]          o_error_variance,
    output logic [skf_pkg::GAIN_W-1:0]          o_gain
);

    localparam int DW = skf_pkg::DATA_W;
    localparam int GW = skf_pkg::GAIN_W;
    localparam int NW = DW + skf_pkg::GAIN_BITS + 1;
    localparam int PW = GW + DW + 1;

    logic [DW-1:0]   r_pn, r_mn, r_est, r_var, r_meas, r_p;
    logic [DW:0]     r_d, r_rem, r_mag;
    logic            r_neg, r_zero;
    logic [GW-1:0]   r_nlow, r_quo, r_gain;
    logic [PW-1:0]   r_prod;
    logic [DW:0]     r_adj;
    logic            r_out_valid;
    logic [DW-1:0]   r_out_est, r_out_var;
    logic [GW-1:0]   r_out_gain;

    // prediction step, gain numerator and denominator, and measurement difference
    logic [DW:0]     p_sum;
    logic [DW-1:0]   p_sat;
    logic [DW:0]     d_sum;
    logic [NW-1:0]   num;
    logic [DW:0]     diff;

    always_comb begin
        p_sum = {1'b0, r_var} + {1'b0, r_pn};
        p_sat = p_sum[DW] ? '1 : p_sum[DW-1:0];
        d_sum = {1'b0, p_sat} + {1'b0, r_mn};
        num   = {1'b0, p_sat, {skf_pkg::GAIN_BITS{1'b0}}} + NW'(d_sum >> 1);
        diff  = {r_meas[DW-1], r_meas} - {r_est[DW-1], r_est};
    end

    // one restoring divide step per cycle
    logic [DW+1:0] rem_sh;
    logic          q_bit;
    logic [DW+1:0] rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_nlow[GW-1]};
        rem_sub = rem_sh - {1'b0, r_d};
        q_bit   = (rem_sh >= {1'b0, r_d});
    end

    // gain and shared multiplier
    logic [GW-1:0] gain_c;
    logic [GW-1:0] mul_a;
    logic [DW:0]   mul_b;
    logic [PW-1:0] mul_y;

    always_comb begin
        if (r_zero) begin
            gain_c = '0;
        end else if (r_quo > skf_pkg::GAIN_ONE) begin
            gain_c = skf_pkg::GAIN_ONE;
        end else begin
            gain_c = r_quo;
        end
        if (i_cmd.mul_est) begin
            mul_a = gain_c;
            mul_b = r_mag;
        end else begin
            mul_a = skf_pkg::GAIN_ONE - r_gain;
            mul_b = {1'b0, r_p};
        end
        mul_y = PW'(mul_a) * PW'(mul_b);
    end

    localparam logic [PW-1:0] HALF = PW'(32'd1 << (skf_pkg::GAIN_BITS - 1));

    logic [PW-1:0] adj_rnd, var_rnd;
    logic [DW+1:0] est_sum;
    logic [DW-1:0] est_sat;
    logic [DW-1:0] var_new;

    always_comb begin
        adj_rnd = r_prod + HALF;
        var_rnd = r_prod + HALF;
        var_new = var_rnd[skf_pkg::GAIN_BITS +: DW];
        if (r_neg) begin
            est_sum = {{2{r_est[DW-1]}}, r_est} - {1'b0, r_adj};
        end else begin
            est_sum = {{2{r_est[DW-1]}}, r_est} + {1'b0, r_adj};
        end
        // clamp to the signed register range
        if (est_sum[DW+1:DW-1] == 3'b000 || est_sum[DW+1:DW-1] == 3'b111) begin
            est_sat = est_sum[DW-1:0];
        end else if (est_sum[DW+1]) begin
            est_sat = {1'b1, {(DW-1){1'b0}}};
        end else begin
            est_sat = {1'b0, {(DW-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pn        <= skf_pkg::PN_RESET;
            r_mn        <= skf_pkg::MN_RESET;
            r_est       <= '0;
            r_var       <= skf_pkg::VAR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == skf_pkg::CFG_PROCESS_NOISE) begin
                    r_pn <= i_cfg_data;
                end else if (i_cfg_addr == skf_pkg::CFG_MEASUREMENT_NOISE) begin
                    r_mn <= i_cfg_data;
                end
            end
            if (i_cmd.commit) begin
                r_est       <= est_sat;
                r_var       <= var_new;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_meas <= i_meas;
        end
        if (i_cmd.pred) begin
            r_p    <= p_sat;
            r_d    <= d_sum;
            r_zero <= (d_sum == '0);
            r_rem  <= (DW+1)'(num[NW-1:GW]);
            r_nlow <= num[GW-1:0];
            r_quo  <= '0;
            r_neg  <= diff[DW];
            r_mag  <= diff[DW] ? -diff : diff;
        end
        if (i_cmd.div_step) begin
            r_rem  <= q_bit ? rem_sub[DW:0] : rem_sh[DW:0];
            r_nlow <= {r_nlow[GW-2:0], 1'b0};
            r_quo  <= {r_quo[GW-2:0], q_bit};
        end
        if (i_cmd.mul_est) begin
            r_gain <= gain_c;
            r_prod <= mul_y;
        end
        if (i_cmd.mul_var) begin
            r_adj  <= adj_rnd[skf_pkg::GAIN_BITS +: (DW+1)];
            r_prod <= mul_y;
        end
        if (i_cmd.commit) begin
            r_out_est  <= est_sat;
            r_out_var  <= var_new;
            r_out_gain <= r_gain;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_estimate        = r_out_est;
    assign o_error_variance  = r_out_var;
    assign o_gain            = r_out_gain;

endmodule

/* rtl/core/scalar_kalman_filter_core.sv */
// channel      dir  signals                          contents
// request in   in   s_axis_tvalid/tready/tdata       measurement
// result out   out  m_axis_tvalid/tready/tdata       estimate, error_variance, gain
// config       in   i_cfg_we/i_cfg_addr/i_cfg_data   0 process_noise, 1 measurement_noise
//
// a request goes from acceptance to result through the predict step, the restoring gain
// divider (one quotient bit a cycle), the estimate and variance products on the shared
// 17x33 multiplier and the commit step
// the next request is taken the cycle after the commit, even if a result still waits in
// the output register; a stalled output holds the commit cycle
// reset restores the register defaults, zero estimate and unit variance
module scalar_kalman_filter_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [skf_pkg::DATA_W-1:0]          s_axis_tdata,   // [31:0] measurement
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] estimate, [63:32] error_variance, [80:64] gain, rest zero
    output logic [skf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [skf_pkg::CFG_IDX_W-1:0]       i_cfg_addr,
    input  logic [skf_pkg::DATA_W-1:0]          i_cfg_data
);

    skf_pkg::t_cmd    cmd;
    skf_pkg::t_status status;
    logic [skf_pkg::DATA_W-1:0] estimate, error_variance;
    logic [skf_pkg::GAIN_W-1:0] gain;

    skf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    skf_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_data       (i_cfg_data),
        .i_meas           (s_axis_tdata),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .o_estimate       (estimate),
        .o_error_variance (error_variance),
        .o_gain           (gain)
    );

    assign m_axis_tdata = skf_pkg::OUT_TDATA_W'({gain, error_variance, estimate});

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;
    import skf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] U32_MAX = 32'hFFFF_FFFF;
    localparam longint EST_MAX = 64'sd2147483647;
    localparam longint EST_MIN = -64'sd2147483648;
    localparam logic [63:0] HALF_GAIN = 64'd1 << (GAIN_BITS - 1);

    localparam int N_BLOCKS        = 17;
    localparam int ITEMS_PER_BLOCK = 100;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 30;

    typedef struct packed {
        logic [DATA_W-1:0] estimate;
        logic [DATA_W-1:0] variance;
        logic [GAIN_W-1:0] gain;
    } t_filter_out;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_WRITE
    } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [DATA_W-1:0]     value;
        logic                  known;
        t_filter_out           want;
    } t_dir_row;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [DATA_W-1:0]      s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_addr    = '0;
    logic [DATA_W-1:0]      i_cfg_data    = '0;

    // filter state and register copies held alongside the block
    logic [DATA_W-1:0] kf_estimate           = '0;
    logic [DATA_W-1:0] kf_variance           = VAR_RESET;
    logic [DATA_W-1:0] cfg_process_noise     = PN_RESET;
    logic [DATA_W-1:0] cfg_measurement_noise = MN_RESET;

    t_filter_out pending_results[$];
    int mismatches     = 0;
    int src_idle_pct   = 0;
    int sink_idle_pct  = 0;
    int stall_requests = 0;
    int stall_served   = 0;
    int rx_hold        = 0;

    scalar_kalman_filter_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    initial begin
        #5_000_000;
        $display("** scalar_kalman_filter_core: FAILED **");
        $finish;
    end

    // one filter step: predict, gain, update; returns the result and advances the state
    function automatic t_filter_out kalman_update(input logic [DATA_W-1:0] meas);
        t_filter_out res;
        logic [63:0] p_pred, d_sum, k, mag, adj_mag, new_var;
        longint est_old, diff, est_new;
        p_pred = 64'(kf_variance) + 64'(cfg_process_noise);
        if (p_pred > 64'(U32_MAX)) begin
            p_pred = 64'(U32_MAX);
        end
        d_sum = p_pred + 64'(cfg_measurement_noise);
        if (d_sum == 64'd0) begin
            k = 64'd0;
        end else begin
            k = ((p_pred << GAIN_BITS) + (d_sum >> 1)) / d_sum;
        end
        if (k > 64'(GAIN_ONE)) begin
            k = 64'(GAIN_ONE);
        end
        est_old = longint'($signed(kf_estimate));
        diff    = longint'($signed(meas)) - est_old;
        mag     = (diff < 0) ? 64'(-diff) : 64'(diff);
        // magnitude rounding gives ties away from zero
        adj_mag = (k * mag + HALF_GAIN) >> GAIN_BITS;
        est_new = (diff < 0) ? est_old - longint'(adj_mag) : est_old + longint'(adj_mag);
        if (est_new > EST_MAX) begin
            est_new = EST_MAX;
        end else if (est_new < EST_MIN) begin
            est_new = EST_MIN;
        end
        new_var = ((64'(GAIN_ONE) - k) * p_pred + HALF_GAIN) >> GAIN_BITS;
        if (new_var > 64'(U32_MAX)) begin
            new_var = 64'(U32_MAX);
        end
        kf_estimate  = DATA_W'(est_new);
        kf_variance  = DATA_W'(new_var);
        res.estimate = kf_estimate;
        res.variance = kf_variance;
        res.gain     = GAIN_W'(k);
        return res;
    endfunction

    function automatic t_dir_row dir_meas(input logic [DATA_W-1:0] meas);
        t_dir_row r;
        r       = '0;
        r.kind  = ROW_SAMPLE;
        r.value = meas;
        return r;
    endfunction

    function automatic t_dir_row dir_meas_known(input logic [DATA_W-1:0] meas,
                                                input logic [DATA_W-1:0] est,
                                                input logic [DATA_W-1:0] variance,
                                                input logic [GAIN_W-1:0] gain);
        t_dir_row r;
        r               = dir_meas(meas);
        r.known         = 1'b1;
        r.want.estimate = est;
        r.want.variance = variance;
        r.want.gain     = gain;
        return r;
    endfunction

    function automatic t_dir_row dir_reg(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [DATA_W-1:0] val);
        t_dir_row r;
        r       = '0;
        r.kind  = ROW_WRITE;
        r.idx   = idx;
        r.value = val;
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] pick_noise(input bit nonzero);
        logic [DATA_W-1:0] v;
        case ($urandom_range(6))
            0:       v = '0;
            1:       v = U32_MAX;
            2:       v = $urandom_range(255);
            3:       v = nonzero ? MN_RESET : PN_RESET;
            4:       v = $urandom_range(32'h0010_0000);
            default: v = $urandom;
        endcase
        if (nonzero && v == '0) begin
            v = 32'd1;
        end
        return v;
    endfunction

    task automatic wait_drained();
        while (pending_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // registers change only with the filter idle and no request offered
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (4) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_PROCESS_NOISE) begin
            cfg_process_noise = val;
        end else if (idx == CFG_MEASUREMENT_NOISE) begin
            cfg_measurement_noise = val;
        end
    endtask

    // entered and left on a falling edge
    task automatic send_sample(input logic [DATA_W-1:0] meas, input logic known,
                               input t_filter_out want);
        t_filter_out res;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= meas;
        do @(posedge i_clk); while (!s_axis_tready);
        res = kalman_update(meas);
        pending_results.push_back(known ? want : res);
        @(negedge i_clk);
    endtask

    // receiver, with a long hold-off on request so the block backs up
    always @(negedge i_clk) begin
        if (rx_hold == 0 && stall_served != stall_requests) begin
            stall_served = stall_requests;
            rx_hold      = HOLD_CYCLES;
        end
        if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_filter_out got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.estimate = m_axis_tdata[DATA_W-1:0];
            got.variance = m_axis_tdata[2*DATA_W-1:DATA_W];
            got.gain     = m_axis_tdata[2*DATA_W+GAIN_W-1:2*DATA_W];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result est %h var %h gain %h",
                         $time, got.estimate, got.variance, got.gain);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (got.estimate !== want.estimate) begin
                    $display("%0t: estimate expected %h actual %h",
                             $time, want.estimate, got.estimate);
                    mismatches++;
                end
                if (got.variance !== want.variance) begin
                    $display("%0t: error_variance expected %h actual %h",
                             $time, want.variance, got.variance);
                    mismatches++;
                end
                if (got.gain !== want.gain) begin
                    $display("%0t: gain expected %h actual %h",
                             $time, want.gain, got.gain);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        t_dir_row          rows[$];
        t_filter_out       none;
        logic [DATA_W-1:0] meas;
        logic [DATA_W-1:0] last_meas;
        int                mode;
        int                phase;

        none      = '0;
        last_meas = '0;

        // defaults after reset
        rows.push_back(dir_meas(32'h0000_0000));
        rows.push_back(dir_meas(S32_MAX));
        rows.push_back(dir_meas(S32_MIN));
        rows.push_back(dir_meas(U32_MAX));
        rows.push_back(dir_meas(32'h0001_0000));
        // no noise at all: full gain once, then a zero divisor
        rows.push_back(dir_reg(CFG_PROCESS_NOISE, '0));
        rows.push_back(dir_reg(CFG_MEASUREMENT_NOISE, '0));
        rows.push_back(dir_meas_known(S32_MAX, S32_MAX, '0, GAIN_ONE));
        rows.push_back(dir_meas_known(S32_MIN, S32_MAX, '0, '0));
        rows.push_back(dir_meas_known(32'h1234_5678, S32_MAX, '0, '0));
        // writes to unused indexes leave the filter alone
        rows.push_back(dir_reg(CFG_SPARE_2, 32'd5));
        rows.push_back(dir_reg(CFG_SPARE_3, U32_MAX));
        rows.push_back(dir_meas_known(32'h0000_0000, S32_MAX, '0, '0));
        // full-scale swing across the whole range
        rows.push_back(dir_reg(CFG_PROCESS_NOISE, U32_MAX));
        rows.push_back(dir_meas_known(S32_MIN, S32_MIN, '0, GAIN_ONE));
        // predicted variance saturates
        rows.push_back(dir_reg(CFG_MEASUREMENT_NOISE, U32_MAX));
        rows.push_back(dir_meas(S32_MAX));
        rows.push_back(dir_meas(S32_MAX));
        rows.push_back(dir_meas(32'hAAAA_5555));
        rows.push_back(dir_reg(CFG_MEASUREMENT_NOISE, 32'd1));
        rows.push_back(dir_meas(32'h0000_0000));
        rows.push_back(dir_meas(S32_MIN));
        rows.push_back(dir_meas(S32_MAX));
        rows.push_back(dir_meas(32'h0000_0001));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        src_idle_pct  = 25;
        sink_idle_pct = 54;
        foreach (rows[i]) begin
            if (rows[i].kind == ROW_WRITE) begin
                write_reg(rows[i].idx, rows[i].value);
            end else begin
                send_sample(rows[i].value, rows[i].known, rows[i].want);
            end
        end

        for (int blk = 0; blk < N_BLOCKS; blk++) begin
            phase = blk * 3 / N_BLOCKS;
            case (phase)
                0: begin
                    src_idle_pct  = 25;
                    sink_idle_pct = 54;
                end
                1: begin
                    src_idle_pct  = 54;
                    sink_idle_pct = 25;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            write_reg(CFG_PROCESS_NOISE, pick_noise(1'b0));
            write_reg(CFG_MEASUREMENT_NOISE, pick_noise(1'b1));
            if (blk == 2 || blk == 12) begin
                stall_requests++;
            end
            for (int n = 0; n < ITEMS_PER_BLOCK; n++) begin
                mode = $urandom_range(99);
                // mostly a slowly wandering signal, some wide jumps and rail values
                if (mode < 60) begin
                    meas = last_meas + ($urandom_range(32'h000F_FFFF) - 32'h0008_0000);
                end else if (mode < 85) begin
                    meas = $urandom;
                end else begin
                    case ($urandom_range(3))
                        0:       meas = S32_MAX;
                        1:       meas = S32_MIN;
                        2:       meas = U32_MAX;
                        default: meas = '0;
                    endcase
                end
                last_meas = meas;
                send_sample(meas, 1'b0, none);
            end
        end

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("** scalar_kalman_filter_core: PASSED **");
        end else begin
            $display("** scalar_kalman_filter_core: FAILED **");
        end
        $finish;
    end

endmodule
